// ----- rtl/core/pme_pkg.sv -----
`default_nettype none

package pme_pkg;

    typedef logic [1:0] t_func;

    localparam t_func FUNC_LOAD    = 2'd0;
    localparam t_func FUNC_RESTART = 2'd1;
    localparam t_func FUNC_NEXT    = 2'd2;

    localparam int unsigned ROW_W    = 8;
    localparam int unsigned PACK_MAX = 8;
    localparam int unsigned WORD_W   = 32;

endpackage

`default_nettype wire

// ----- rtl/core/pme_ram.sv -----
`default_nettype none

module pme_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/perfect_matching_enumerator.sv -----
`default_nettype none

// Enumerates perfect matchings of books to persons by backtracking search.
// Load a row with func 0 (person, book_mask), rewind with func 1, and ask for
// the next assignment with func 2. A command is taken when start is high and
// busy is low. Func 2 always answers with one word on o_strobe, one cycle wide:
// either the next assignment (nibble k = person number from 1 for book k) or
// o_exhausted with a zero assignment. The receiver cannot stall; results are
// simply presented for that one cycle. Loads and restarts leave the block idle
// and give no word. A next request passes through a test and a check state
// for each candidate tested and a pop and a test state for each backtrack step,
// since each step reads the row or stack memory, which is registered; after a
// match it delivers the word and pops the last level. Once the search is
// exhausted the word comes in the cycle after the request. At the other end, a
// full 8 by 8 matrix with one book that nobody accepts walks the whole tree.
// Writing the item count also rewinds the search. Rows read as zero until loaded.
module perfect_matching_enumerator #(
    parameter int unsigned MAX_ITEMS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire pme_pkg::t_func     i_func,
    input  wire logic [2:0]         i_person,
    input  wire logic [7:0]         i_book_mask,
    input  wire logic               i_cfg_we,
    input  wire logic [3:0]         i_cfg_item_count,
    output logic                    o_strobe,
    output logic [31:0]             o_assignment,
    output logic                    o_exhausted
);

    import pme_pkg::*;

    localparam int unsigned LIM = (MAX_ITEMS < PACK_MAX) ? MAX_ITEMS : PACK_MAX;
    localparam int unsigned RAW = (LIM > 1) ? $clog2(LIM) : 1;
    localparam logic [3:0]  LIM4  = 4'(LIM);
    localparam logic [3:0]  MAXI4 = 4'(MAX_ITEMS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TEST = 2'd1;
    localparam logic [1:0] S_CHK  = 2'd2;
    localparam logic [1:0] S_POP  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [3:0]        r_count, n_count;
    logic [3:0]        r_level, n_level;
    logic [3:0]        r_cand, n_cand;
    logic [LIM-1:0]    r_used, n_used;
    logic              r_done, n_done;
    logic              r_resume, n_resume;
    logic [WORD_W-1:0] r_word, n_word;
    logic [LIM-1:0]    r_row_vld, n_row_vld;
    logic              r_rd_vld;
    logic              r_strobe, n_strobe;
    logic [WORD_W-1:0] r_assign, n_assign;
    logic              r_exh, n_exh;

    logic [3:0]       act;
    logic [3:0]       lvl_m1;
    logic [3:0]       cnt_m1;
    logic [3:0]       stk_sel;
    logic             pref_we;
    logic [RAW-1:0]   pref_waddr;
    logic [RAW-1:0]   pref_raddr;
    logic [ROW_W-1:0] pref_rdata;
    logic             stk_we;
    logic [RAW-1:0]   stk_waddr;
    logic [RAW-1:0]   stk_wdata;
    logic [RAW-1:0]   stk_raddr;
    logic [RAW-1:0]   stk_rdata;

    assign act        = (r_count < LIM4) ? r_count : LIM4;
    assign lvl_m1     = r_level - 4'd1;
    assign cnt_m1     = act - 4'd1;
    assign stk_sel    = (r_level >= act) ? cnt_m1 : lvl_m1;
    assign stk_raddr  = stk_sel[RAW-1:0];
    assign pref_raddr = r_cand[RAW-1:0];
    assign pref_waddr = i_person[RAW-1:0];
    assign stk_waddr  = r_level[RAW-1:0];
    assign stk_wdata  = r_cand[RAW-1:0];

    pme_ram #(
        .WIDTH (ROW_W),
        .DEPTH (LIM)
    ) u_pref_ram (
        .i_clk   (i_clk),
        .i_we    (pref_we),
        .i_waddr (pref_waddr),
        .i_wdata (i_book_mask),
        .i_raddr (pref_raddr),
        .o_rdata (pref_rdata)
    );

    pme_ram #(
        .WIDTH (RAW),
        .DEPTH (LIM)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_level   = r_level;
        n_cand    = r_cand;
        n_used    = r_used;
        n_done    = r_done;
        n_resume  = r_resume;
        n_word    = r_word;
        n_row_vld = r_row_vld;
        n_strobe  = 1'b0;
        n_assign  = r_assign;
        n_exh     = r_exh;
        pref_we   = 1'b0;
        stk_we    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_func)
                        FUNC_LOAD: begin
                            if ({1'b0, i_person} < MAXI4) begin
                                pref_we               = 1'b1;
                                n_row_vld[pref_waddr] = 1'b1;
                            end
                        end
                        FUNC_RESTART: begin
                            n_used  = '0;
                            n_level = '0;
                            n_cand  = '0;
                            n_done  = 1'b0;
                            n_word  = '0;
                        end
                        FUNC_NEXT: begin
                            if (r_done) begin
                                n_strobe = 1'b1;
                                n_assign = '0;
                                n_exh    = 1'b1;
                            end else begin
                                n_state = S_TEST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TEST: begin
                if (r_level >= act) begin
                    n_strobe = 1'b1;
                    n_assign = r_word;
                    n_exh    = 1'b0;
                    if (act == 4'd0) begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_level  = cnt_m1;
                        n_resume = 1'b0;
                        n_state  = S_POP;
                    end
                end else if (r_cand >= act) begin
                    if (r_level == 4'd0) begin
                        n_done   = 1'b1;
                        n_strobe = 1'b1;
                        n_assign = '0;
                        n_exh    = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_level  = lvl_m1;
                        n_resume = 1'b1;
                        n_state  = S_POP;
                    end
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_rd_vld && pref_rdata[r_level[2:0]] && !r_used[r_cand[RAW-1:0]]) begin
                    stk_we                          = 1'b1;
                    n_used[r_cand[RAW-1:0]]         = 1'b1;
                    n_word[{r_level[2:0], 2'b00} +: 4] = r_cand + 4'd1;
                    n_level                         = r_level + 4'd1;
                    n_cand                          = '0;
                end else begin
                    n_cand = r_cand + 4'd1;
                end
                n_state = S_TEST;
            end
            S_POP: begin
                n_used[stk_rdata] = 1'b0;
                n_cand            = 4'(stk_rdata) + 4'd1;
                n_state           = r_resume ? S_TEST : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_count = i_cfg_item_count;
            n_used  = '0;
            n_level = '0;
            n_cand  = '0;
            n_done  = 1'b0;
            n_word  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= 4'd1;
            r_level   <= '0;
            r_cand    <= '0;
            r_used    <= '0;
            r_done    <= 1'b0;
            r_resume  <= 1'b0;
            r_word    <= '0;
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_level   <= n_level;
            r_cand    <= n_cand;
            r_used    <= n_used;
            r_done    <= n_done;
            r_resume  <= n_resume;
            r_word    <= n_word;
            r_row_vld <= n_row_vld;
            r_rd_vld  <= r_row_vld[pref_raddr];
            r_strobe  <= n_strobe;
        end
    end

    // result word registers
    always_ff @(posedge i_clk) begin
        r_assign <= n_assign;
        r_exh    <= n_exh;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_assignment = r_assign;
    assign o_exhausted  = r_exh;

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    import pme_pkg::*;

    localparam int MAX_ITEMS = 8;
    localparam int IDLE_LIMIT = 100000;
    localparam int RANDOM_ITEMS = 450;
    localparam t_func FUNC_UNUSED = 2'd3;

    typedef struct packed {
        t_func      func;
        logic [2:0] person;
        logic [7:0] mask;
    } t_cmd_word;

    typedef struct packed {
        logic [31:0] assignment;
        logic        exhausted;
    } t_match_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_func       i_func = FUNC_LOAD;
    logic [2:0]  i_person = 3'd0;
    logic [7:0]  i_book_mask = 8'd0;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_item_count = 4'd1;
    logic        o_strobe;
    logic [31:0] o_assignment;
    logic        o_exhausted;

    perfect_matching_enumerator #(
        .MAX_ITEMS(MAX_ITEMS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_person         (i_person),
        .i_book_mask      (i_book_mask),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_item_count (i_cfg_item_count),
        .o_strobe         (o_strobe),
        .o_assignment     (o_assignment),
        .o_exhausted      (o_exhausted)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // matching search state, mirrored from the block
    logic [3:0]  item_count;
    logic [7:0]  pref_rows [8];
    logic [15:0] person_used;
    logic [3:0]  chosen_person [16];
    logic [3:0]  next_cand [16];
    int          search_level;
    bit          search_done;

    t_cmd_word   pending_cmds[$];
    t_match_word expected_words[$];
    t_cmd_word   cur_cmd;
    t_match_word got_word;
    t_match_word want_word;
    int          burst_left = 0;
    int          gap_left = 0;
    int          idle_cycles = 0;
    int          mismatch_count = 0;
    int          random_items = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic int active_items();
        int n;
        n = item_count;
        if (n > MAX_ITEMS) n = MAX_ITEMS;
        if (n > 8) n = 8;
        return n;
    endfunction

    function automatic void rewind_search();
        for (int k = 0; k < 16; k++) begin
            chosen_person[k] = '0;
            next_cand[k] = '0;
        end
        person_used = '0;
        search_level = 0;
        search_done = 1'b0;
    endfunction

    function automatic void write_count_model(input logic [3:0] v);
        item_count = v;
        rewind_search();
    endfunction

    function automatic bit search_to_next_match(output logic [31:0] packed_word);
        int  n;
        int  lvl;
        int  p;
        bit  found;
        logic [3:0] nib;
        n = active_items();
        packed_word = '0;
        while (1'b1) begin
            lvl = search_level;
            if (lvl >= n) begin
                for (int k = 0; k < n; k++) begin
                    nib = chosen_person[k] + 4'd1;
                    packed_word = packed_word | (32'(nib) << (4 * k));
                end
                if (n == 0) begin
                    search_done = 1'b1;
                end else begin
                    search_level = n - 1;
                    person_used[chosen_person[n - 1]] = 1'b0;
                end
                return 1'b1;
            end
            found = 1'b0;
            for (p = int'(next_cand[lvl]); p < n; p++) begin
                if (pref_rows[p][lvl] && !person_used[p]) begin
                    found = 1'b1;
                    break;
                end
            end
            if (found) begin
                chosen_person[lvl] = 4'(p);
                person_used[p] = 1'b1;
                next_cand[lvl] = 4'(p + 1);
                search_level = lvl + 1;
                next_cand[lvl + 1] = '0;
            end else begin
                next_cand[lvl] = 4'(n);
                if (lvl == 0) begin
                    search_done = 1'b1;
                    return 1'b0;
                end
                search_level = lvl - 1;
                person_used[chosen_person[lvl - 1]] = 1'b0;
            end
        end
        return 1'b0;
    endfunction

    function automatic void predict_cmd(input t_cmd_word c);
        logic [31:0] w;
        bit          ok;
        case (c.func)
            FUNC_LOAD: begin
                if (int'(c.person) < MAX_ITEMS) pref_rows[c.person] = c.mask;
            end
            FUNC_RESTART: begin
                rewind_search();
            end
            FUNC_NEXT: begin
                w = '0;
                ok = 1'b0;
                if (!search_done) ok = search_to_next_match(w);
                expected_words.push_back('{assignment: ok ? w : 32'd0, exhausted: !ok});
            end
            default: begin
            end
        endcase
    endfunction

    // driver: bursts of words with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) predict_cmd(cur_cmd);
            if (start && busy) begin
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                cur_cmd = pending_cmds.pop_front();
                i_func <= cur_cmd.func;
                i_person <= cur_cmd.person;
                i_book_mask <= cur_cmd.mask;
                start <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 1) ? $urandom_range(1, 6)
                                                      : $urandom_range(10, 40);
                    gap_left = $urandom_range(0, 5);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            got_word = '{assignment: o_assignment, exhausted: o_exhausted};
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h/%b", o_assignment, o_exhausted));
            end else begin
                want_word = expected_words.pop_front();
                if (got_word.assignment !== want_word.assignment)
                    report_mismatch($sformatf("assignment %h, wanted %h",
                                              got_word.assignment, want_word.assignment));
                if (got_word.exhausted !== want_word.exhausted)
                    report_mismatch($sformatf("exhausted %b, wanted %b",
                                              got_word.exhausted, want_word.exhausted));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_cmd(input t_func f, input logic [2:0] p, input logic [7:0] m);
        pending_cmds.push_back('{func: f, person: p, mask: m});
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || start || expected_words.size() != 0)
            @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_item_count(input logic [3:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_item_count <= v;
        write_count_model(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // sparse rows keep the search short at the largest counts
    function automatic logic [7:0] random_row(input int nn);
        if (nn >= 7) return 8'($urandom & $urandom & $urandom);
        return 8'($urandom);
    endfunction

    initial begin
        int          r;
        int          n;
        int          nn;
        int          tries;
        int          j;
        int          tmp;
        int          perm [8];
        logic [7:0]  m;

        item_count = 4'd1;
        for (int k = 0; k < 8; k++) pref_rows[k] = '0;
        rewind_search();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // rows still clear after reset
        push_cmd(FUNC_NEXT, 3'd0, 8'h00);
        push_cmd(FUNC_NEXT, 3'd7, 8'hff);
        wait_drained();

        // empty assignment once, then exhausted, then again after a restart
        write_item_count(4'd0);
        push_cmd(FUNC_NEXT, 3'd0, 8'h00);
        push_cmd(FUNC_NEXT, 3'd0, 8'h00);
        push_cmd(FUNC_UNUSED, 3'd5, 8'haa);
        push_cmd(FUNC_RESTART, 3'd0, 8'h00);
        push_cmd(FUNC_NEXT, 3'd0, 8'h00);
        wait_drained();

        // count above the cap, full matrix, row changed mid-search
        write_item_count(4'd15);
        for (int k = 0; k < 8; k++) push_cmd(FUNC_LOAD, 3'(k), 8'hff);
        push_cmd(FUNC_NEXT, 3'd0, 8'h00);
        push_cmd(FUNC_NEXT, 3'd0, 8'h00);
        push_cmd(FUNC_LOAD, 3'd2, 8'h04);
        push_cmd(FUNC_NEXT, 3'd0, 8'h00);
        push_cmd(FUNC_RESTART, 3'd0, 8'h00);
        push_cmd(FUNC_NEXT, 3'd0, 8'h00);
        push_cmd(FUNC_UNUSED, 3'd7, 8'hff);
        wait_drained();

        while (random_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 4) n = 0;
            else if (r < 8) n = $urandom_range(9, 15);
            else if (r < 70) n = $urandom_range(1, 5);
            else n = $urandom_range(6, 8);
            nn = (n > 8) ? 8 : n;
            write_item_count(4'(n));

            for (int k = 0; k < 8; k++) perm[k] = k;
            for (int k = 7; k > 0; k--) begin
                j = $urandom_range(0, k);
                tmp = perm[k];
                perm[k] = perm[j];
                perm[j] = tmp;
            end
            for (int k = 0; k < 8; k++) begin
                m = random_row(nn);
                if (k < nn && $urandom_range(0, 4) != 0) m = m | (8'd1 << perm[k]);
                push_cmd(FUNC_LOAD, 3'(k), m);
                random_items++;
            end
            if ($urandom_range(0, 1)) begin
                push_cmd(FUNC_RESTART, 3'($urandom), 8'($urandom));
                random_items++;
            end
            tries = $urandom_range(2, 14);
            for (int k = 0; k < tries; k++) begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    push_cmd(FUNC_UNUSED, 3'($urandom), 8'($urandom));
                end else if (r < 10) begin
                    push_cmd(FUNC_RESTART, 3'($urandom), 8'($urandom));
                    random_items++;
                end else if (r < 17) begin
                    push_cmd(FUNC_LOAD, 3'($urandom), random_row(nn));
                    random_items++;
                end else begin
                    push_cmd(FUNC_NEXT, 3'($urandom), 8'($urandom));
                    random_items++;
                end
            end
            wait_drained();
        end

        write_item_count(4'd1);
        push_cmd(FUNC_LOAD, 3'd0, 8'h01);
        push_cmd(FUNC_NEXT, 3'd0, 8'h00);
        push_cmd(FUNC_NEXT, 3'd0, 8'h00);
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (expected_words.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
